// ===== sv/pcb_pkg.sv =====
// shared types and constants for the particle cell binning block
`default_nettype none

package pcb_pkg;

  localparam int POS_W   = 32;
  localparam int SCALE_W = 32;
  localparam int PACK_W  = 48;
  localparam int IDX_W   = 48;
  localparam int CFG_IDX_W = 3;
  localparam int NSTG    = 5;

  localparam logic [SCALE_W-1:0] SCALE_RST = 32'h0001_0000;
  localparam logic [PACK_W-1:0]  OFFS_RST  = 48'h0000_0000_0000;
  localparam logic [PACK_W-1:0]  DIMS_RST  = 48'h0001_0001_0001;
  localparam logic [PACK_W-1:0]  SIDES_RST = 48'h0001_0001_0001;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [SCALE_W-1:0]      scale_t;
  typedef logic [PACK_W-1:0]       pack_t;
  typedef logic [IDX_W-1:0]        index_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ABOVE      = 2'd1,
    ST_BELOW      = 2'd2,
    ST_NEG_GLOBAL = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_X     = 3'd0,
    CFG_SCALE_Y     = 3'd1,
    CFG_SCALE_Z     = 3'd2,
    CFG_SUB_OFFSETS = 3'd3,
    CFG_SUB_DIMS    = 3'd4,
    CFG_SIDE_COUNTS = 3'd5
  } cfg_reg_t;

  // load enables for pipeline stages 1..NSTG
  typedef struct packed {
    logic [NSTG:1] en;
  } pipe_ctl_t;

  typedef struct packed {
    logic above;
    logic neg;
    logic zero_dim;
  } axis_flags_t;

endpackage

`default_nettype wire

// ===== sv/pcb_if.sv =====
// valid/ready channel interfaces for positions and binning results
`default_nettype none

interface pcb_in_if;
  logic          valid;
  logic          ready;
  pcb_pkg::pos_t pos_x;
  pcb_pkg::pos_t pos_y;
  pcb_pkg::pos_t pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface pcb_out_if;
  logic              valid;
  logic              ready;
  pcb_pkg::index_t   local_index;
  pcb_pkg::index_t   global_index;
  pcb_pkg::status_t  status;

  modport source (output valid, local_index, global_index, status, input ready);
  modport sink   (input valid, local_index, global_index, status, output ready);
endinterface

`default_nettype wire

// ===== sv/particle_cell_binning.sv =====
// top level: bins a Q-format particle position into a uniform 3d cell grid
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+----------------------------------------
//   in_ch    | in  | valid/ready      | pos_x, pos_y, pos_z
//   out_ch   | out | valid/ready      | local_index, global_index, status
//   cfg_*    | in  | cfg_we, no ready | cfg_index, cfg_data
//
// one item per cycle sustained while out_ch is not stalled
// each item is registered in turn through the stages: scale multiply, offset add and truncate,
// bound check and clamp, inner index multiply, outer index multiply
// reset clears the stage valid bits and loads the register defaults
// a stalled output holds its stage; upstream stages keep filling empty slots

`default_nettype none

module particle_cell_binning #(
  parameter int AXIS_BITS = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  pcb_in_if.sink                                 in_ch,
  pcb_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [pcb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pcb_pkg::PACK_W-1:0]        cfg_data
);

  pcb_pkg::scale_t scale_x_r, scale_y_r, scale_z_r;
  pcb_pkg::pack_t  sub_offsets_r, sub_dims_r, side_counts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r     <= pcb_pkg::SCALE_RST;
      scale_y_r     <= pcb_pkg::SCALE_RST;
      scale_z_r     <= pcb_pkg::SCALE_RST;
      sub_offsets_r <= pcb_pkg::OFFS_RST;
      sub_dims_r    <= pcb_pkg::DIMS_RST;
      side_counts_r <= pcb_pkg::SIDES_RST;
    end else if (cfg_we) begin
      unique case (pcb_pkg::cfg_reg_t'(cfg_index))
        pcb_pkg::CFG_SCALE_X:     scale_x_r     <= cfg_data[pcb_pkg::SCALE_W-1:0];
        pcb_pkg::CFG_SCALE_Y:     scale_y_r     <= cfg_data[pcb_pkg::SCALE_W-1:0];
        pcb_pkg::CFG_SCALE_Z:     scale_z_r     <= cfg_data[pcb_pkg::SCALE_W-1:0];
        pcb_pkg::CFG_SUB_OFFSETS: sub_offsets_r <= cfg_data;
        pcb_pkg::CFG_SUB_DIMS:    sub_dims_r    <= cfg_data;
        pcb_pkg::CFG_SIDE_COUNTS: side_counts_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // packed fields, zero above the register width
  logic [63:0] offs_ext, dims_ext, sides_ext;

  assign offs_ext  = {16'b0, sub_offsets_r};
  assign dims_ext  = {16'b0, sub_dims_r};
  assign sides_ext = {16'b0, side_counts_r};

  logic [AXIS_BITS-1:0] off_x, off_y, off_z;
  logic [AXIS_BITS-1:0] dim_x, dim_y, dim_z;
  logic [AXIS_BITS-1:0] side_x, side_y, side_z;

  assign off_x  = offs_ext[0 +: AXIS_BITS];
  assign off_y  = offs_ext[AXIS_BITS +: AXIS_BITS];
  assign off_z  = offs_ext[2*AXIS_BITS +: AXIS_BITS];
  assign dim_x  = dims_ext[0 +: AXIS_BITS];
  assign dim_y  = dims_ext[AXIS_BITS +: AXIS_BITS];
  assign dim_z  = dims_ext[2*AXIS_BITS +: AXIS_BITS];
  assign side_x = sides_ext[0 +: AXIS_BITS];
  assign side_y = sides_ext[AXIS_BITS +: AXIS_BITS];
  assign side_z = sides_ext[2*AXIS_BITS +: AXIS_BITS];

  pcb_pkg::pipe_ctl_t ctl;

  pcb_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl)
  );

  logic [AXIS_BITS-1:0]  lx, ly, lz;
  logic [AXIS_BITS:0]    gx, gy, gz;
  pcb_pkg::axis_flags_t  fx, fy, fz;

  pcb_axis #(.AXIS_BITS(AXIS_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk   (clk),
    .ctl   (ctl),
    .pos   (in_ch.pos_x),
    .scale (scale_x_r),
    .side  (side_x),
    .off   (off_x),
    .dim   (dim_x),
    .loc   (lx),
    .glb   (gx),
    .flags (fx)
  );

  pcb_axis #(.AXIS_BITS(AXIS_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk   (clk),
    .ctl   (ctl),
    .pos   (in_ch.pos_y),
    .scale (scale_y_r),
    .side  (side_y),
    .off   (off_y),
    .dim   (dim_y),
    .loc   (ly),
    .glb   (gy),
    .flags (fy)
  );

  pcb_axis #(.AXIS_BITS(AXIS_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_z (
    .clk   (clk),
    .ctl   (ctl),
    .pos   (in_ch.pos_z),
    .scale (scale_z_r),
    .side  (side_z),
    .off   (off_z),
    .dim   (dim_z),
    .loc   (lz),
    .glb   (gz),
    .flags (fz)
  );

  pcb_linear #(.AXIS_BITS(AXIS_BITS)) u_linear (
    .clk          (clk),
    .ctl          (ctl),
    .lx           (lx),
    .ly           (ly),
    .lz           (lz),
    .gx           (gx),
    .gy           (gy),
    .gz           (gz),
    .fx           (fx),
    .fy           (fy),
    .fz           (fz),
    .dx           (dim_x),
    .dy           (dim_y),
    .sx           (side_x),
    .sy           (side_y),
    .local_index  (out_ch.local_index),
    .global_index (out_ch.global_index),
    .status       (out_ch.status)
  );

endmodule

`default_nettype wire

// ===== sv/pcb_ctl.sv =====
// valid bits and stall control for the binning pipeline
`default_nettype none

module pcb_ctl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pcb_pkg::pipe_ctl_t      ctl
);

  logic [pcb_pkg::NSTG:1]   vld_r;
  logic [pcb_pkg::NSTG:1]   vld_nxt;
  logic [pcb_pkg::NSTG:1]   prev;
  logic [pcb_pkg::NSTG+1:1] en;

  always_comb begin
    // a stage loads when it is empty or the stage after it moves
    en[pcb_pkg::NSTG+1] = out_ready;
    for (int k = pcb_pkg::NSTG; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    prev    = {vld_r[pcb_pkg::NSTG-1:1], in_valid};
    vld_nxt = vld_r;
    for (int k = 1; k <= pcb_pkg::NSTG; k++) begin
      if (en[k]) begin
        vld_nxt[k] = prev[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.en    = en[pcb_pkg::NSTG:1];
  assign in_ready  = en[1];
  assign out_valid = vld_r[pcb_pkg::NSTG];

endmodule

`default_nettype wire

// ===== sv/pcb_axis.sv =====
// one axis: scale multiply, offset and truncate, bound check and clamp
`default_nettype none

module pcb_axis #(
  parameter int AXIS_BITS = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                    clk,
  input  wire pcb_pkg::pipe_ctl_t      ctl,
  input  wire pcb_pkg::pos_t           pos,
  input  wire pcb_pkg::scale_t         scale,
  input  wire logic [AXIS_BITS-1:0]    side,
  input  wire logic [AXIS_BITS-1:0]    off,
  input  wire logic [AXIS_BITS-1:0]    dim,
  output logic [AXIS_BITS-1:0]         loc,
  output logic [AXIS_BITS:0]           glb,
  output pcb_pkg::axis_flags_t         flags
);

  localparam int PW = pcb_pkg::POS_W + pcb_pkg::SCALE_W;
  localparam int SW = AXIS_BITS + 2;
  localparam int BW = SW + 2 * FRAC_BITS - 1;
  localparam int NW = ((BW > PW) ? BW : PW) + 1;
  localparam int LW = NW - 2 * FRAC_BITS;

  // stage 1: signed position times unsigned scale
  logic signed [PW-1:0] prod_nxt;
  logic signed [PW-1:0] prod_r;

  assign prod_nxt = pos * $signed({1'b0, scale});

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      prod_r <= prod_nxt;
    end
  end

  // stage 2: add (side - 2*off)/2 in product units, truncate toward zero
  logic signed [SW-1:0] sterm;
  logic [NW-1:0]        bias;
  logic [NW-1:0]        num;
  logic [LW-1:0]        floor_v;
  logic                 frac_nz;
  logic [LW-1:0]        l_nxt;
  logic [LW-1:0]        l_r;

  always_comb begin
    sterm   = $signed({2'b00, side}) - $signed({1'b0, off, 1'b0});
    bias    = {{(NW-SW){sterm[SW-1]}}, sterm} << (2 * FRAC_BITS - 1);
    num     = {{(NW-PW){prod_r[PW-1]}}, prod_r} + bias;
    floor_v = num[NW-1:2*FRAC_BITS];
    frac_nz = |num[2*FRAC_BITS-1:0];
    l_nxt   = floor_v + {{(LW-1){1'b0}}, num[NW-1] & frac_nz};
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      l_r <= l_nxt;
    end
  end

  // stage 3: bounds and drift clamp
  logic [LW-1:0]          dim_ext;
  logic                   eq_dim;
  logic [AXIS_BITS-1:0]   loc_nxt;
  pcb_pkg::axis_flags_t   flags_nxt;

  always_comb begin
    dim_ext            = {{(LW-AXIS_BITS){1'b0}}, dim};
    eq_dim             = (l_r == dim_ext);
    flags_nxt.above    = $signed(l_r) > $signed(dim_ext);
    flags_nxt.neg      = l_r[LW-1];
    flags_nxt.zero_dim = eq_dim && (dim == '0);
    loc_nxt            = eq_dim ? (l_r[AXIS_BITS-1:0] - AXIS_BITS'(1)) : l_r[AXIS_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      loc   <= loc_nxt;
      glb   <= {1'b0, loc_nxt} + {1'b0, off};
      flags <= flags_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pcb_linear.sv =====
// linear cell indices from per-axis coordinates, status and error zeroing
`default_nettype none

module pcb_linear #(
  parameter int AXIS_BITS = 16
) (
  input  wire logic                  clk,
  input  wire pcb_pkg::pipe_ctl_t    ctl,
  input  wire logic [AXIS_BITS-1:0]  lx,
  input  wire logic [AXIS_BITS-1:0]  ly,
  input  wire logic [AXIS_BITS-1:0]  lz,
  input  wire logic [AXIS_BITS:0]    gx,
  input  wire logic [AXIS_BITS:0]    gy,
  input  wire logic [AXIS_BITS:0]    gz,
  input  wire pcb_pkg::axis_flags_t  fx,
  input  wire pcb_pkg::axis_flags_t  fy,
  input  wire pcb_pkg::axis_flags_t  fz,
  input  wire logic [AXIS_BITS-1:0]  dx,
  input  wire logic [AXIS_BITS-1:0]  dy,
  input  wire logic [AXIS_BITS-1:0]  sx,
  input  wire logic [AXIS_BITS-1:0]  sy,
  output pcb_pkg::index_t            local_index,
  output pcb_pkg::index_t            global_index,
  output pcb_pkg::status_t           status
);

  localparam int A = AXIS_BITS;

  // stage 4: inner products and error status
  logic [2*A-1:0]        lp;
  logic [2*A:0]          gp;
  logic [2*A:0]          lin_r;
  logic [2*A+1:0]        gin_r;
  logic [A-1:0]          lx4_r;
  logic [A:0]            gx4_r;
  pcb_pkg::status_t      st4_nxt;
  pcb_pkg::status_t      st4_r;

  always_comb begin
    lp = dy * lz;
    gp = sy * gz;
    priority if (fx.above || fy.above || fz.above) begin
      st4_nxt = pcb_pkg::ST_ABOVE;
    end else if (fx.neg || fy.neg || fz.neg ||
                 fx.zero_dim || fy.zero_dim || fz.zero_dim) begin
      st4_nxt = pcb_pkg::ST_BELOW;
    end else begin
      st4_nxt = pcb_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      lin_r <= {1'b0, lp} + {{(A+1){1'b0}}, ly};
      gin_r <= {1'b0, gp} + {{(A+1){1'b0}}, gy};
      lx4_r <= lx;
      gx4_r <= gx;
      st4_r <= st4_nxt;
    end
  end

  // stage 5: outer products, wrap to 64 bits, sign check of global index
  logic [3*A:0]          lprod;
  logic [3*A+1:0]        lfull;
  logic [3*A+1:0]        gprod;
  logic [3*A+2:0]        gfull;
  logic [3*A+1+pcb_pkg::IDX_W:0] lwide;
  logic [3*A+2+64:0]     gwide;
  logic [63:0]           g64;
  pcb_pkg::index_t       lidx_nxt;
  pcb_pkg::index_t       gidx_nxt;
  pcb_pkg::status_t      st_nxt;

  always_comb begin
    lprod = dx * lin_r;
    lfull = {1'b0, lprod} + {{(2*A+2){1'b0}}, lx4_r};
    gprod = sx * gin_r;
    gfull = {1'b0, gprod} + {{(2*A+2){1'b0}}, gx4_r};
    lwide = {{pcb_pkg::IDX_W{1'b0}}, lfull};
    gwide = {64'b0, gfull};
    g64   = gwide[63:0];
    lidx_nxt = '0;
    gidx_nxt = '0;
    if (st4_r != pcb_pkg::ST_OK) begin
      st_nxt = st4_r;
    end else if (g64[63]) begin
      st_nxt = pcb_pkg::ST_NEG_GLOBAL;
    end else begin
      st_nxt   = pcb_pkg::ST_OK;
      lidx_nxt = lwide[pcb_pkg::IDX_W-1:0];
      gidx_nxt = g64[pcb_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      local_index  <= lidx_nxt;
      global_index <= gidx_nxt;
      status       <= st_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pcb_checker.sv =====
// port-level checks for the binning block, bound to the top level
`default_nettype none

module pcb_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire pcb_pkg::index_t   local_index,
  input wire pcb_pkg::index_t   global_index,
  input wire pcb_pkg::status_t  status
);

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // errors carry zero indices
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != pcb_pkg::ST_OK) |-> (local_index == '0) && (global_index == '0))
    else $error("nonzero index on error status");

  // input only backs up when the whole pipe is full behind a stalled output
  a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back pressure");

  // reset empties the pipe
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind particle_cell_binning pcb_checker u_pcb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .local_index  (out_ch.local_index),
  .global_index (out_ch.global_index),
  .status       (out_ch.status)
);

`default_nettype wire
